/* hw/rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// shared types and sizes for the sorted key table and its cell row
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // broadcast write enables for the whole row
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

  // raw compare flags of one cell, seen by its neighbors
  typedef struct packed {
    logic le;
    logic ge;
    logic eq;
  } cell_flags_t;

  // boundary hits of one cell, gathered by the top level
  typedef struct packed {
    logic floor;
    logic match;
    logic gap;
  } cell_hits_t;

endpackage

/* hw/rtl/sorted_key_table_floor_search.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_floor_search
// sorted key/payload table with floor search, insert and remove, built as a
// row of compare-and-shift cells
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ----------------------------------
// in_       input      in_valid / in_ready    cmd, key, payload
// out_      output     out_valid / out_ready  status, slot, found_key,
//                                             found_payload, exact, entry_count
//
// every command passes S_IDLE, which captures it, then S_EXEC, in which all cells
// compare their key with it in parallel and, once the output register is free,
// the row shifts and the result register loads; the per-cell compare plus the
// 64-way boundary encode set its path; rst_n (synchronous, active low) clears the
// entry count and handshake state; table contents are not cleared, entries past
// the count are never read; a stalled result holds in the output register; the
// next command is taken meanwhile and waits in S_EXEC until the output register frees
//
module sorted_key_table_floor_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [31:0] out_found_key,
  output logic [31:0] out_found_payload,
  output logic        out_exact,
  output logic [6:0]  out_entry_count
);
  import skt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [KEY_W-1:0] fkey_r, fkey_nxt;
  logic [PAY_W-1:0] fpay_r, fpay_nxt;
  logic             exact_r, exact_nxt;

  logic             in_xfer;
  logic             commit;
  logic             full;
  logic             any_match;
  cell_ctl_t        ctl;

  cell_flags_t      flags [CAPACITY];
  cell_hits_t       hits  [CAPACITY];
  logic [KEY_W-1:0] keys  [CAPACITY];
  logic [PAY_W-1:0] pays  [CAPACITY];

  logic [CAPACITY-1:0] floor_v, match_v, gap_v;
  logic [IDX_W-1:0]    floor_idx, match_idx, gap_idx;
  logic [KEY_W-1:0]    floor_key;
  logic [PAY_W-1:0]    floor_pay;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // execute cycle finishes once the output register is free or being drained
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign any_match = |match_v;

  assign ctl.ins_en = commit && (cmd_r == CMD_INSERT) && !full;
  assign ctl.rem_en = commit && (cmd_r == CMD_REMOVE) && any_match;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_flags_t      lo_f, hi_f;
    logic [KEY_W-1:0] lo_k, hi_k;
    logic [PAY_W-1:0] lo_p, hi_p;

    if (i == 0) begin : g_first
      assign lo_f = '0;
      assign lo_k = '0;
      assign lo_p = '0;
    end else begin : g_mid_lo
      assign lo_f = flags[i-1];
      assign lo_k = keys[i-1];
      assign lo_p = pays[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_f = '0;
      assign hi_k = '0;
      assign hi_p = '0;
    end else begin : g_mid_hi
      assign hi_f = flags[i+1];
      assign hi_k = keys[i+1];
      assign hi_p = pays[i+1];
    end

    skt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .srch_key (key_r),
      .new_pay  (pay_r),
      .occ      (CNT_W'(i) < count_r),
      .tail     (CNT_W'(i) == count_r),
      .lo_flags (lo_f),
      .hi_flags (hi_f),
      .lo_key   (lo_k),
      .lo_pay   (lo_p),
      .hi_key   (hi_k),
      .hi_pay   (hi_p),
      .flags    (flags[i]),
      .hits     (hits[i]),
      .key_q    (keys[i]),
      .pay_q    (pays[i])
    );

    // when every stored key is above the search key the floor is entry 0
    if (i == 0) begin : g_floor0
      assign floor_v[i] = hits[i].floor || (flags[i].ge && !flags[i].le);
    end else begin : g_floorn
      assign floor_v[i] = hits[i].floor;
    end
    assign match_v[i] = hits[i].match;
    assign gap_v[i]   = hits[i].gap;
  end

  // one-hot boundaries to index and data
  always_comb begin
    floor_idx = '0;
    match_idx = '0;
    gap_idx   = '0;
    floor_key = '0;
    floor_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (floor_v[i]) begin
        floor_idx = floor_idx | IDX_W'(i);
        floor_key = floor_key | keys[i];
        floor_pay = floor_pay | pays[i];
      end
      if (match_v[i]) match_idx = match_idx | IDX_W'(i);
      if (gap_v[i])   gap_idx   = gap_idx | IDX_W'(i);
    end
  end

  // result and next count
  always_comb begin
    status_nxt = ST_OK;
    slot_nxt   = '0;
    fkey_nxt   = '0;
    fpay_nxt   = '0;
    exact_nxt  = 1'b0;
    count_nxt  = count_r;
    unique case (cmd_r)
      CMD_SEARCH: begin
        if (count_r == '0) begin
          status_nxt = ST_MISS;
        end else begin
          slot_nxt  = floor_idx;
          fkey_nxt  = floor_key;
          fpay_nxt  = floor_pay;
          exact_nxt = (floor_key == key_r);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          slot_nxt  = gap_idx;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (any_match) begin
          slot_nxt  = match_idx;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_EXEC;
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) count_r <= count_nxt;
    end
  end

  // command capture and result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= in_key;
      pay_r <= PAY_W'(in_payload);
    end
    if (commit) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      fkey_r   <= fkey_nxt;
      fpay_r   <= fpay_nxt;
      exact_r  <= exact_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_slot          = 6'(slot_r);
  assign out_found_key     = fkey_r;
  assign out_found_payload = 32'(fpay_r);
  assign out_exact         = exact_r;
  assign out_entry_count   = 7'(count_r);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_floor_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(floor_v))
    else $error("more than one floor boundary in the row");

  a_gap_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && !full) |-> $onehot(gap_v))
    else $error("insert position not unique");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && (state_r == S_IDLE))
    else $error("execute cycle did not produce a result");

endmodule

/* hw/rtl/skt_cell.sv */
// ----------------------------------------------------------------------------
// skt_cell
// one table slot: holds a key and payload, compares against the broadcast
// key and shifts to or from its neighbors on insert and remove
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                       clk,
  input  skt_pkg::cell_ctl_t         ctl,
  input  logic [skt_pkg::KEY_W-1:0]  srch_key,
  input  logic [skt_pkg::PAY_W-1:0]  new_pay,
  input  logic                       occ,
  input  logic                       tail,
  input  skt_pkg::cell_flags_t       lo_flags,
  input  skt_pkg::cell_flags_t       hi_flags,
  input  logic [skt_pkg::KEY_W-1:0]  lo_key,
  input  logic [skt_pkg::PAY_W-1:0]  lo_pay,
  input  logic [skt_pkg::KEY_W-1:0]  hi_key,
  input  logic [skt_pkg::PAY_W-1:0]  hi_pay,
  output skt_pkg::cell_flags_t       flags,
  output skt_pkg::cell_hits_t        hits,
  output logic [skt_pkg::KEY_W-1:0]  key_q,
  output logic [skt_pkg::PAY_W-1:0]  pay_q
);
  import skt_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic             wr_en;

  always_comb begin
    flags.le = occ && (key_r <= srch_key);
    flags.ge = occ && (key_r >= srch_key);
    flags.eq = occ && (key_r == srch_key);
    // last key not above the search key
    hits.floor = flags.le && !hi_flags.le;
    // first equal key
    hits.match = flags.eq && !lo_flags.eq;
    // insert lands here: first key not below, or the free slot past the end
    hits.gap = (tail || flags.ge) && !lo_flags.ge;
  end

  always_comb begin
    wr_en   = 1'b0;
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctl.ins_en && lo_flags.ge) begin
      wr_en   = 1'b1;
      key_nxt = lo_key;
      pay_nxt = lo_pay;
    end else if (ctl.ins_en && hits.gap) begin
      wr_en   = 1'b1;
      key_nxt = srch_key;
      pay_nxt = new_pay;
    end else if (ctl.rem_en && flags.ge) begin
      wr_en   = 1'b1;
      key_nxt = hi_key;
      pay_nxt = hi_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r <= key_nxt;
      pay_r <= pay_nxt;
    end
  end

  assign key_q = key_r;
  assign pay_q = pay_r;

endmodule

/* sim/sorted_key_table_floor_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_floor_search_tb
// self-checking bench for the sorted key table: a short directed table, then
// random fill / drain / mixed phases, every result checked against a local
// model of the sorted table or typed-in values, both channels idling at random
// ----------------------------------------------------------------------------
module sorted_key_table_floor_search_tb;
  import skt_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int MIXED_LEN    = 120;

  // one result transfer, laid out like the out_ ports
  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [KEY_W-1:0]   found_key;
    logic [31:0]        found_payload;
    logic               exact;
    logic [CNT_W-1:0]   entry_count;
  } table_result_t;

  // one row of the directed table; want is used only when has_want is set
  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [31:0]        payload;
    logic               has_want;
    table_result_t      want;
  } directed_row_t;

  // random stimulus phases: grow to full, shrink to empty, then churn
  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_NOP;
  logic [31:0] in_key = '0;
  logic [31:0] in_payload = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_slot;
  logic [31:0] out_found_key;
  logic [31:0] out_found_payload;
  logic        out_exact;
  logic [6:0]  out_entry_count;

  sorted_key_table_floor_search DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_found_key     (out_found_key),
    .out_found_payload (out_found_payload),
    .out_exact         (out_exact),
    .out_entry_count   (out_entry_count)
  );

  // local copy of the table: entries below table_fill are sorted by key
  logic [KEY_W-1:0] table_keys [CAPACITY];
  logic [PAY_W-1:0] table_pays [CAPACITY];
  int               table_fill = 0;

  // results still owed by the block, oldest first
  table_result_t    pending_results [$];
  directed_row_t    directed_rows [$];

  int mismatches = 0;
  int cycle_count = 0;
  int tx_calm = 0;          // sender items left with no gaps
  int rx_calm = 0;          // receiver cycles left always ready
  int rx_stall = 0;         // receiver cycles left of the current stall
  table_result_t got_result;
  table_result_t want_result;

  // free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // table model
  // --------------------------------------------------------------------------

  function automatic table_result_t make_result(status_t st, int slot,
                                                logic [KEY_W-1:0] fkey,
                                                logic [31:0] fpay,
                                                logic hit, int count);
    table_result_t res;
    res.status        = st;
    res.slot          = IDX_W'(slot);
    res.found_key     = fkey;
    res.found_payload = fpay;
    res.exact         = hit;
    res.entry_count   = CNT_W'(count);
    return res;
  endfunction

  // applies one command to the local table and returns the result it owes
  function automatic table_result_t apply_table_cmd(cmd_t cmd, logic [KEY_W-1:0] key,
                                                    logic [31:0] pay);
    int i;
    int j;
    table_result_t res;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_SEARCH: begin
        if (table_fill == 0) begin
          res.status = ST_MISS;
        end else begin
          // walk down to the last key not above the search key, or entry 0
          i = table_fill - 1;
          while (i > 0 && key < table_keys[i]) i--;
          res.slot          = IDX_W'(i);
          res.found_key     = table_keys[i];
          res.found_payload = 32'(table_pays[i]);
          res.exact         = (table_keys[i] == key);
        end
      end
      CMD_INSERT: begin
        if (table_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // shift up every key not below the new one, so it lands before equals
          i = table_fill;
          while (i > 0 && key <= table_keys[i-1]) begin
            table_keys[i] = table_keys[i-1];
            table_pays[i] = table_pays[i-1];
            i--;
          end
          table_keys[i] = key;
          table_pays[i] = pay[PAY_W-1:0];
          table_fill++;
          res.slot = IDX_W'(i);
        end
      end
      CMD_REMOVE: begin
        i = 0;
        while (i < table_fill && table_keys[i] != key) i++;
        if (i >= table_fill) begin
          res.status = ST_MISS;
        end else begin
          // first equal key goes, the rest close the gap
          table_fill--;
          for (j = i; j < table_fill; j++) begin
            table_keys[j] = table_keys[j+1];
            table_pays[j] = table_pays[j+1];
          end
          res.slot = IDX_W'(i);
        end
      end
      default: ;  // unused command: no change, plain ok
    endcase
    res.entry_count = CNT_W'(table_fill);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // random helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // keys: near stored ones, a small crowded range, the extremes, or anything
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    int r;
    int nudge;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (table_fill > 0 && r < hit_pct) begin
      k = table_keys[$urandom_range(0, table_fill - 1)];
      nudge = $urandom_range(0, 3);
      if (nudge == 2) k = k + 1'b1;
      else if (nudge == 3) k = k - 1'b1;
    end else if (r < hit_pct + 30) begin
      k = KEY_W'($urandom_range(0, 15));
    end else if (r < hit_pct + 40) begin
      // 0, 1, all ones, all ones minus one
      k = ($urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}})
          ^ KEY_W'($urandom_range(0, 1));
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  function automatic logic [31:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // input channel
  // --------------------------------------------------------------------------

  // one command transfer; the expectation is queued at the accepting edge
  task automatic send_cmd(cmd_t cmd, logic [KEY_W-1:0] key, logic [31:0] pay,
                          logic has_want, table_result_t want);
    int gap;
    table_result_t predicted;
    gap = (tx_calm > 0) ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_key     <= key;
    in_payload <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_table_cmd(cmd, key, pay);
    pending_results.push_back(has_want ? want : predicted);
    if (tx_calm > 0) tx_calm--;
  endtask

  // stop sending until the block owes nothing
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(cmd_t cmd, logic [KEY_W-1:0] key, logic [31:0] pay,
                         logic has_want, table_result_t want);
    directed_row_t row;
    row.cmd      = cmd;
    row.key      = key;
    row.payload  = pay;
    row.has_want = has_want;
    row.want     = want;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  initial begin
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    phase_t           phase;
    int               r;
    int               n_items;
    int               phase_items;
    int               full_hits;
    int               empty_hits;
    logic             paused;
    logic             full_refused;
    logic             on_empty;

    // directed table: expectations typed in where they are plain to see
    // search and remove on an empty table, and an unused command
    add_row(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1,
            make_result(ST_MISS, 0, '0, '0, 1'b0, 0));
    add_row(CMD_REMOVE, 32'h0000_0005, 32'h0000_0000, 1'b1,
            make_result(ST_MISS, 0, '0, '0, 1'b0, 0));
    add_row(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            make_result(ST_OK, 0, '0, '0, 1'b0, 0));
    // first entry, then exact hit and a search below every key
    add_row(CMD_INSERT, 32'd100, 32'hAAAA_5555, 1'b1,
            make_result(ST_OK, 0, '0, '0, 1'b0, 1));
    add_row(CMD_SEARCH, 32'd100, 32'h0000_0000, 1'b1,
            make_result(ST_OK, 0, 32'd100, 32'hAAAA_5555, 1'b1, 1));
    add_row(CMD_SEARCH, 32'd50, 32'hFFFF_FFFF, 1'b1,
            make_result(ST_OK, 0, 32'd100, 32'hAAAA_5555, 1'b0, 1));
    // key extremes, and a duplicate key that must land before its equal
    add_row(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_INSERT, 32'd100, 32'h1234_5678, 1'b0, '0);
    add_row(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_SEARCH, 32'd99, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_SEARCH, 32'd100, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_SEARCH, 32'd101, 32'hFFFF_FFFF, 1'b0, '0);
    // remove the first of the equal pair, a missing key, then empty it
    add_row(CMD_REMOVE, 32'd100, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_REMOVE, 32'd7, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_NOP, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_REMOVE, 32'd100, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_SEARCH, 32'd100, 32'h0000_0000, 1'b1,
            make_result(ST_MISS, 0, '0, '0, 1'b0, 0));
    add_row(CMD_INSERT, 32'd7, 32'h0000_0000, 1'b0, '0);

    // synchronous reset, then release
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].payload,
               directed_rows[i].has_want, directed_rows[i].want);
    end
    hold_until_drained();

    // random part: fill to full, drain to empty, churn, and round again
    phase       = PH_FILL;
    n_items     = 0;
    phase_items = 0;
    full_hits   = 0;
    empty_hits  = 0;
    paused      = 1'b0;
    while (n_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  cmd = (r < 78) ? CMD_INSERT : (r < 92) ? CMD_SEARCH :
                        (r < 97) ? CMD_REMOVE : CMD_NOP;
        PH_DRAIN: cmd = (r < 75) ? CMD_REMOVE : (r < 90) ? CMD_SEARCH :
                        (r < 97) ? CMD_INSERT : CMD_NOP;
        default:  cmd = (r < 33) ? CMD_INSERT : (r < 66) ? CMD_REMOVE :
                        (r < 97) ? CMD_SEARCH : CMD_NOP;
      endcase
      // removes aim at stored keys, harder while draining
      key = pick_key((cmd == CMD_REMOVE && phase == PH_DRAIN) ? 85 : 45);

      full_refused = (cmd == CMD_INSERT) && (table_fill == CAPACITY);
      on_empty     = (cmd == CMD_SEARCH || cmd == CMD_REMOVE) && (table_fill == 0);
      // once per phase, let the pipe run dry right before a boundary command
      if ((full_refused || on_empty) && !paused) begin
        hold_until_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 149) == 0) tx_calm = $urandom_range(30, 80);

      send_cmd(cmd, key, pick_payload(), 1'b0, '0);
      if (cmd != CMD_NOP) n_items++;
      if (full_refused) full_hits++;
      if (on_empty) empty_hits++;
      phase_items++;

      case (phase)
        PH_FILL: begin
          if (table_fill == CAPACITY && full_hits >= 4) begin
            phase = PH_DRAIN;
            phase_items = 0;
            full_hits = 0;
            empty_hits = 0;
            paused = 1'b0;
          end
        end
        PH_DRAIN: begin
          if (table_fill == 0 && empty_hits >= 3) begin
            phase = PH_MIXED;
            phase_items = 0;
            full_hits = 0;
            empty_hits = 0;
            paused = 1'b0;
          end
        end
        default: begin
          if (phase_items >= MIXED_LEN) begin
            phase = PH_FILL;
            phase_items = 0;
            full_hits = 0;
            empty_hits = 0;
            paused = 1'b0;
          end
        end
      endcase
    end

    // wait out the owed results, then idle on for strays
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result channel: check each transfer, then pick next cycle's ready
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_result.status        = status_t'(out_status);
      got_result.slot          = out_slot;
      got_result.found_key     = out_found_key;
      got_result.found_payload = out_found_payload;
      got_result.exact         = out_exact;
      got_result.entry_count   = out_entry_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result transfer with nothing expected: status %0d slot %0d count %0d",
                   out_status, out_slot, out_entry_count);
        end
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected status %0d slot %0d key %h payload %h exact %0b count %0d",
                     want_result.status, want_result.slot, want_result.found_key,
                     want_result.found_payload, want_result.exact, want_result.entry_count);
            $display("          actual   status %0d slot %0d key %h payload %h exact %0b count %0d",
                     got_result.status, got_result.slot, got_result.found_key,
                     got_result.found_payload, got_result.exact, got_result.entry_count);
          end
        end
      end
    end

    // ready: calm stretches, otherwise random stalls of mostly short length
    if (rx_calm > 0) begin
      rx_calm--;
      out_ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(40, 120);
      rx_stall = (rx_calm > 0) ? 0 : pick_idle();
      out_ready <= (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_floor_search.sv
sim/sorted_key_table_floor_search_tb.sv
